// ===== rtl/sha256_stream_hasher_assert.svh =====
// Assertion macros for the checker file of the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SHS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("SHA-256 hasher assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("SHA-256 hasher assertion failed");

`endif

// ===== rtl/shs_pkg.sv =====
// Types and constants shared by the SHA-256 stream hasher modules.
package shs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_ZERO,
    ST_LEN,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        shift_en;
    logic        init_en;
    logic        round_en;
    logic        fold_en;
    logic        iv_en;
    logic [31:0] word;
    logic [5:0]  round;
  } core_ctl_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  localparam logic [7:0][31:0] SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== rtl/shs_core.sv =====
// Round datapath: schedule window, working variables and chain value.
module shs_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  shs_pkg::core_ctl_t     ctl,
  output logic [7:0][31:0]       chain
);

  logic [15:0][31:0] win_r, win_nxt;
  logic [7:0][31:0]  work_r, work_nxt;
  logic [7:0][31:0]  chain_r, chain_nxt;
  logic [31:0]       sched_word;
  logic [31:0]       t1;
  logic [31:0]       t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] sum0(input logic [31:0] x);
    sum0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] sum1(input logic [31:0] x);
    sum1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  always_comb begin
    sched_word = win_r[0] + sig0(win_r[1]) + win_r[9] + sig1(win_r[14]);
    t1 = work_r[7] + sum1(work_r[4]) + ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]))
         + shs_pkg::ROUND_K[ctl.round] + win_r[0];
    t2 = sum0(work_r[0]) + ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2])
         ^ (work_r[1] & work_r[2]));

    win_nxt = win_r;
    if (ctl.shift_en || ctl.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[15] = ctl.round_en ? sched_word : ctl.word;
    end

    work_nxt = work_r;
    if (ctl.init_en) begin
      work_nxt = chain_r;
    end else if (ctl.round_en) begin
      for (int i = 7; i > 0; i--) begin
        work_nxt[i] = work_r[i-1];
      end
      work_nxt[4] = work_r[3] + t1;
      work_nxt[0] = t1 + t2;
    end else if (ctl.fold_en) begin
      for (int i = 0; i < 7; i++) begin
        work_nxt[i] = work_r[i+1];
      end
      work_nxt[7] = work_r[0];
    end

    chain_nxt = chain_r;
    if (ctl.iv_en) begin
      chain_nxt = shs_pkg::SHA_IV;
    end else if (ctl.fold_en) begin
      for (int i = 0; i < 7; i++) begin
        chain_nxt[i] = chain_r[i+1];
      end
      chain_nxt[7] = chain_r[0] + work_r[0];
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    work_r <= work_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= shs_pkg::SHA_IV;
    end else begin
      chain_r <= chain_nxt;
    end
  end

  assign chain = chain_r;

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher: byte packing, padding sequencer, digest output.
//
//   channel   direction  handshake             payload
//   in_*      request    in_valid / in_ready   shs_pkg::in_item_t (byte, byte_valid, last)
//   out_*     result     out_valid / out_ready shs_pkg::out_item_t (word, index, last_word)
//
// A message byte is accepted while the hasher is idle; each filled 64-byte block then goes
// through the shared round unit (64 rounds, one per cycle, and then the chain update).
// A closing request adds the padding bytes, a pause when the zero fill reaches the length
// field, one or two block compressions, and the eight digest words, one per free output
// slot.
// Reset is synchronous and returns the chain value to the initial hash and clears counters.
// in_ready is low while padding, compressing or delivering; a stalled output holds its word.
module sha256_stream_hasher (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  shs_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output shs_pkg::out_item_t   out_data
);

  shs_pkg::state_t    state_r, state_nxt;
  logic [5:0]         pos_r, pos_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [60:0]        bc_r, bc_nxt;
  logic [23:0]        acc_r, acc_nxt;
  logic               pad_r, pad_nxt;
  logic               p80_r, p80_nxt;
  logic               len_r, len_nxt;
  logic               out_valid_r, out_valid_nxt;
  shs_pkg::out_item_t out_data_r, out_data_nxt;
  shs_pkg::core_ctl_t ctl;
  logic [7:0][31:0]   chain;
  logic               push_en;
  logic [7:0]         push_byte;
  logic               full;
  logic [63:0]        len_bits;
  logic               in_acc;
  logic               slot_free;

  shs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .chain (chain)
  );

  assign in_ready  = (state_r == shs_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign len_bits  = {bc_r, 3'b000};
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    bc_nxt        = bc_r;
    acc_nxt       = acc_r;
    pad_nxt       = pad_r;
    p80_nxt       = p80_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    push_en       = 1'b0;
    push_byte     = 8'h00;
    ctl           = '0;

    unique case (state_r)
      shs_pkg::ST_IDLE: begin
        if (in_acc) begin
          pad_nxt = in_data.last;
          if (in_data.byte_valid) begin
            push_en   = 1'b1;
            push_byte = in_data.data_byte;
            bc_nxt    = bc_r + 61'd1;
          end
          if (push_en && (pos_r == shs_pkg::LAST_POS)) begin
            state_nxt = shs_pkg::ST_COMP;
          end else if (in_data.last) begin
            state_nxt = shs_pkg::ST_PAD80;
          end
        end
      end
      shs_pkg::ST_PAD80: begin
        push_en   = 1'b1;
        push_byte = shs_pkg::PAD_BYTE;
        p80_nxt   = 1'b1;
        state_nxt = (pos_r == shs_pkg::LAST_POS) ? shs_pkg::ST_COMP : shs_pkg::ST_ZERO;
      end
      shs_pkg::ST_ZERO: begin
        if (pos_r == shs_pkg::LEN_POS) begin
          state_nxt = shs_pkg::ST_LEN;
        end else begin
          push_en = 1'b1;
          if (pos_r == shs_pkg::LAST_POS) begin
            state_nxt = shs_pkg::ST_COMP;
          end
        end
      end
      shs_pkg::ST_LEN: begin
        push_en   = 1'b1;
        push_byte = len_bits[{3'd7 - pos_r[2:0], 3'b000} +: 8];
        if (pos_r == shs_pkg::LAST_POS) begin
          len_nxt   = 1'b1;
          state_nxt = shs_pkg::ST_COMP;
        end
      end
      shs_pkg::ST_COMP: begin
        ctl.round_en = 1'b1;
        ctl.round    = cnt_r;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == shs_pkg::LAST_POS) begin
          state_nxt = shs_pkg::ST_FOLD;
        end
      end
      shs_pkg::ST_FOLD: begin
        ctl.fold_en = 1'b1;
        cnt_nxt     = cnt_r + 6'd1;
        if (cnt_r[2:0] == 3'd7) begin
          cnt_nxt = 6'd0;
          if (!pad_r) begin
            state_nxt = shs_pkg::ST_IDLE;
          end else if (len_r) begin
            state_nxt = shs_pkg::ST_OUT;
          end else if (p80_r) begin
            state_nxt = shs_pkg::ST_ZERO;
          end else begin
            state_nxt = shs_pkg::ST_PAD80;
          end
        end
      end
      shs_pkg::ST_OUT: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.digest_word = chain[cnt_r[2:0]];
          out_data_nxt.word_index  = cnt_r[2:0];
          out_data_nxt.last_word   = (cnt_r[2:0] == 3'd7);
          cnt_nxt                  = cnt_r + 6'd1;
          if (cnt_r[2:0] == 3'd7) begin
            ctl.iv_en = 1'b1;
            cnt_nxt   = 6'd0;
            bc_nxt    = '0;
            pad_nxt   = 1'b0;
            p80_nxt   = 1'b0;
            len_nxt   = 1'b0;
            state_nxt = shs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = shs_pkg::ST_IDLE;
      end
    endcase

    if (push_en) begin
      acc_nxt      = {acc_r[15:0], push_byte};
      pos_nxt      = pos_r + 6'd1;
      ctl.shift_en = (pos_r[1:0] == 2'b11);
      ctl.word     = {acc_r, push_byte};
    end
    full = push_en && (pos_r == shs_pkg::LAST_POS);
    if (full) begin
      ctl.init_en = 1'b1;
      cnt_nxt     = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shs_pkg::ST_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      bc_r        <= '0;
      pad_r       <= 1'b0;
      p80_r       <= 1'b0;
      len_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      bc_r        <= bc_nxt;
      pad_r       <= pad_nxt;
      p80_r       <= p80_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/shs_chk.sv =====
// Port-level checker for the SHA-256 stream hasher and its bind statement.
`include "sha256_stream_hasher_assert.svh"

module shs_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input shs_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input shs_pkg::out_item_t out_data
);

  // A stalled digest word must hold its value.
  `SHS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // Only the eighth word carries the final flag.
  `SHS_ASSERT_NOW(a_last_word, out_valid, out_data.last_word == (out_data.word_index == 3'd7))

  // While early digest words are pending, the block takes no new request.
  `SHS_ASSERT_NOW(a_busy_out, out_valid && out_data.word_index != 3'd6
                  && out_data.word_index != 3'd7, !in_ready)

  // A closing request starts padding or a block compression, so the next cycle is busy.
  `SHS_ASSERT_NEXT(a_close_busy, in_valid && in_ready && in_data.last, !in_ready)

  // A request with neither a byte nor a close leaves the block ready.
  `SHS_ASSERT_NEXT(a_idle_item, in_valid && in_ready && !in_data.byte_valid && !in_data.last,
                   in_ready)

endmodule

bind sha256_stream_hasher shs_chk u_shs_chk (.*);
